// ===== rtl/ngga_pkg.sv =====
// shared types and constants for the gga field extractor
// no dependencies; imported by every module of the block

package ngga_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_FIX_RST = 8'h79;

    localparam logic [39:0] HDR_GGA = 40'h4750474741;
    localparam logic [39:0] HDR_GSA = 40'h4750475341;

    localparam int BODY_CNT_W = 7;
    localparam logic [BODY_CNT_W-1:0] BODY_LIMIT = BODY_CNT_W'(70);

    localparam int UTC_LEN = 6;
    localparam int LAT_LEN = 9;
    localparam int LON_LEN = 10;
    localparam int SAT_LEN = 2;
    localparam int ALT_LEN = 5;
    localparam int REPORT_LEN = 33;
    localparam int RPT_IDX_W = $clog2(REPORT_LEN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // one accepted word after classification
    typedef struct packed {
        logic       is_report;
        logic       is_dollar;
        logic       is_comma;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef logic [REPORT_LEN-1:0][7:0] rec_t;

endpackage

// ===== rtl/ngga_front.sv =====
// input stage: accepts words and tags them as report request, dollar or comma
// depends on ngga_pkg

module ngga_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [0:0]    s_tuser,
    output logic          push,
    output ngga_pkg::item_t push_item,
    input  logic          q_full
);
    import ngga_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  accept;

    assign push     = valid_reg & ~q_full;
    assign s_tready = ~valid_reg | ~q_full;
    assign accept   = s_tvalid & s_tready;
    assign push_item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept) begin
            valid_next          = 1'b1;
            item_next.is_report = s_tuser[0];
            item_next.is_dollar = ~s_tuser[0] & (s_tdata == CHAR_DOLLAR);
            item_next.is_comma  = ~s_tuser[0] & (s_tdata == CHAR_COMMA);
            item_next.data      = s_tdata;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ===== rtl/ngga_queue.sv =====
// short fifo of classified words between the front and the back
// depends on ngga_pkg

module ngga_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ngga_pkg::item_t push_item,
    output logic            q_full,
    output ngga_pkg::q_head_t head,
    input  logic            pop
);
    import ngga_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign q_full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~q_full;
    assign do_pop     = pop & head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/ngga_parse.sv =====
// sentence parser: header match, field counting and ascii field store
// depends on ngga_pkg

module ngga_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  ngga_pkg::q_head_t head,
    input  logic              rpt_busy,
    output logic              pop_text,
    output ngga_pkg::rec_t    rec
);
    import ngga_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HEADER,
        MODE_GGA,
        MODE_GSA
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [31:0]           hdr_reg, hdr_next;
    logic [39:0]           hdr_full;
    logic [BODY_CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]            fld_reg, fld_next;
    logic [3:0]            chr_reg, chr_next;

    logic [7:0] utc_reg [UTC_LEN];
    logic [7:0] utc_next [UTC_LEN];
    logic [7:0] lat_reg [LAT_LEN];
    logic [7:0] lat_next [LAT_LEN];
    logic [7:0] lon_reg [LON_LEN];
    logic [7:0] lon_next [LON_LEN];
    logic [7:0] sat_reg [SAT_LEN];
    logic [7:0] sat_next [SAT_LEN];
    logic [7:0] alt_reg [ALT_LEN];
    logic [7:0] alt_next [ALT_LEN];
    logic [7:0] fix_reg, fix_next;

    logic [7:0] c;
    logic       gga_char;

    assign pop_text = head.valid & ~head.item.is_report & ~rpt_busy;
    assign c        = head.item.data;
    assign hdr_full = {hdr_reg, c};

    always_comb begin
        mode_next = mode_reg;
        hdr_next  = hdr_reg;
        cnt_next  = cnt_reg;
        fld_next  = fld_reg;
        chr_next  = chr_reg;
        fix_next  = fix_reg;
        utc_next  = utc_reg;
        lat_next  = lat_reg;
        lon_next  = lon_reg;
        sat_next  = sat_reg;
        alt_next  = alt_reg;
        gga_char  = 1'b0;
        if (pop_text) begin
            if (head.item.is_dollar) begin
                mode_next = MODE_HEADER;
                hdr_next  = '0;
                cnt_next  = '0;
                fld_next  = '0;
                chr_next  = '0;
            end else begin
                unique case (mode_reg)
                    MODE_HEADER: begin
                        hdr_next = hdr_full[31:0];
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == BODY_CNT_W'(4)) begin
                            cnt_next = '0;
                            fld_next = '0;
                            chr_next = '0;
                            if (hdr_full == HDR_GGA) begin
                                mode_next = MODE_GGA;
                            end else if (hdr_full == HDR_GSA) begin
                                mode_next = MODE_GSA;
                            end else begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                    MODE_GGA, MODE_GSA: begin
                        if (cnt_reg >= BODY_LIMIT) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                            if (mode_reg == MODE_GSA) begin
                                if (cnt_reg == BODY_CNT_W'(3)) begin
                                    fix_next = c;
                                end
                            end else if (head.item.is_comma) begin
                                if (fld_reg != 4'hF) begin
                                    fld_next = fld_reg + 1'b1;
                                end
                                chr_next = '0;
                            end else begin
                                gga_char = 1'b1;
                                if (chr_reg != 4'hF) begin
                                    chr_next = chr_reg + 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
        // characters past a field's size fall outside every position
        if (gga_char) begin
            for (int i = 0; i < UTC_LEN; i++) begin
                if (fld_reg == 4'd1 && chr_reg == 4'(i)) utc_next[i] = c;
            end
            for (int i = 0; i < LAT_LEN; i++) begin
                if (fld_reg == 4'd2 && chr_reg == 4'(i)) lat_next[i] = c;
            end
            for (int i = 0; i < LON_LEN; i++) begin
                if (fld_reg == 4'd4 && chr_reg == 4'(i)) lon_next[i] = c;
            end
            for (int i = 0; i < SAT_LEN; i++) begin
                if (fld_reg == 4'd7 && chr_reg == 4'(i)) sat_next[i] = c;
            end
            for (int i = 0; i < ALT_LEN; i++) begin
                if (fld_reg == 4'd9 && chr_reg == 4'(i)) alt_next[i] = c;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < UTC_LEN; i++) rec[i] = utc_reg[i];
        for (int i = 0; i < LAT_LEN; i++) rec[UTC_LEN + i] = lat_reg[i];
        for (int i = 0; i < LON_LEN; i++) rec[UTC_LEN + LAT_LEN + i] = lon_reg[i];
        rec[UTC_LEN + LAT_LEN + LON_LEN] = fix_reg;
        for (int i = 0; i < SAT_LEN; i++) begin
            rec[UTC_LEN + LAT_LEN + LON_LEN + 1 + i] = sat_reg[i];
        end
        for (int i = 0; i < ALT_LEN; i++) begin
            rec[UTC_LEN + LAT_LEN + LON_LEN + 1 + SAT_LEN + i] = alt_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            hdr_reg  <= '0;
            cnt_reg  <= '0;
            fld_reg  <= '0;
            chr_reg  <= '0;
            fix_reg  <= CHAR_FIX_RST;
            for (int i = 0; i < UTC_LEN; i++) utc_reg[i] <= CHAR_ZERO;
            for (int i = 0; i < LAT_LEN; i++) lat_reg[i] <= CHAR_ZERO;
            for (int i = 0; i < LON_LEN; i++) lon_reg[i] <= CHAR_ZERO;
            for (int i = 0; i < SAT_LEN; i++) sat_reg[i] <= CHAR_ZERO;
            for (int i = 0; i < ALT_LEN; i++) alt_reg[i] <= CHAR_ZERO;
        end else begin
            mode_reg <= mode_next;
            hdr_reg  <= hdr_next;
            cnt_reg  <= cnt_next;
            fld_reg  <= fld_next;
            chr_reg  <= chr_next;
            fix_reg  <= fix_next;
            utc_reg  <= utc_next;
            lat_reg  <= lat_next;
            lon_reg  <= lon_next;
            sat_reg  <= sat_next;
            alt_reg  <= alt_next;
        end
    end

endmodule

// ===== rtl/ngga_report.sv =====
// report sequencer: walks the 33-byte record into the output register
// depends on ngga_pkg

module ngga_report (
    input  logic              aclk,
    input  logic              aresetn,
    input  ngga_pkg::q_head_t head,
    input  ngga_pkg::rec_t    rec,
    output logic              busy,
    output logic              pop_rpt,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import ngga_pkg::*;

    logic                 busy_reg, busy_next;
    logic [RPT_IDX_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           data_reg, data_next;
    logic                 last_reg, last_next;
    logic                 load, at_end;

    // record stays frozen while busy since no text word is popped meanwhile
    assign pop_rpt  = head.valid & head.item.is_report & ~busy_reg;
    assign busy     = busy_reg;
    assign load     = busy_reg & (~valid_reg | m_tready);
    assign at_end   = (idx_reg == RPT_IDX_W'(REPORT_LEN - 1));
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (pop_rpt) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        if (load) begin
            valid_next = 1'b1;
            data_next  = rec[idx_reg];
            last_next  = at_end;
            idx_next   = idx_reg + 1'b1;
            if (at_end) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/nmea_gga_field_extractor.sv =====
// top level of the gga field extractor: front stage, queue, parser and report
// depends on ngga_pkg, ngga_front, ngga_queue, ngga_parse, ngga_report
//
//   bus   | dir | tdata         | tuser / tlast
//   s_*   | in  | [7:0] rx_byte | tuser[0] action (1 = report request)
//   m_*   | out | [7:0] out_byte| tlast on the 33rd report byte
//
// a text word is parsed as it leaves the queue; words may follow back to back
// a report request gives 33 words, one a cycle while m_tready is high
// text words behind a report wait in the 4-deep queue until its last byte is loaded
// aresetn (synchronous) restores all fields to ascii zero and fix mode to 'y'
// either side may stall without loss; the queue lets the input run on meanwhile

module nmea_gga_field_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import ngga_pkg::*;

    logic    push, q_full, pop_text, pop_rpt, rpt_busy;
    item_t   push_item;
    q_head_t head;
    rec_t    rec;

    ngga_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    ngga_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .head      (head),
        .pop       (pop_text | pop_rpt)
    );

    ngga_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .rpt_busy (rpt_busy),
        .pop_text (pop_text),
        .rec      (rec)
    );

    ngga_report u_report (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .rec      (rec),
        .busy     (rpt_busy),
        .pop_rpt  (pop_rpt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/ngga_checker.sv =====
// port-level checks for the gga field extractor, bound to the top level
// depends on ngga_pkg and nmea_gga_field_extractor

module ngga_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import ngga_pkg::*;

    logic [RPT_IDX_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic                 out_acc;

    assign out_acc = m_tvalid & m_tready;

    always_comb begin
        byte_cnt_next = byte_cnt_reg;
        if (out_acc) begin
            byte_cnt_next = m_tlast ? '0 : byte_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
        end else begin
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // tlast marks exactly the 33rd word of a report
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_tlast |-> byte_cnt_reg == RPT_IDX_W'(REPORT_LEN - 1))
        else $error("tlast not on the final report byte");

    a_no_long: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !m_tlast |-> byte_cnt_reg < RPT_IDX_W'(REPORT_LEN - 1))
        else $error("report longer than 33 bytes");

    // reset leaves nothing to send
    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

    // reset leaves the input side ready for a word
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready straight after reset");

endmodule

bind nmea_gga_field_extractor ngga_checker u_ngga_checker (.*);
